>>> rtl/core/pmfp_pkg.sv
`default_nettype none

package pmfp_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned HdrPosW   = 3;
  localparam int unsigned CapIdxW   = 4;
  localparam int unsigned HeaderLen = 5;
  localparam int unsigned CaptureLen = 11;

  localparam logic [ByteW-1:0]   SkipLenReset = 8'd30;
  localparam logic [HdrPosW-1:0] HdrLast      = 3'(HeaderLen - 1);
  localparam logic [CapIdxW-1:0] CapLast      = 4'(CaptureLen - 1);

  localparam logic [CapIdxW-1:0] CapSysHi   = 4'd0;
  localparam logic [CapIdxW-1:0] CapSysLo   = 4'd1;
  localparam logic [CapIdxW-1:0] CapDiaHi   = 4'd3;
  localparam logic [CapIdxW-1:0] CapDiaLo   = 4'd4;
  localparam logic [CapIdxW-1:0] CapPulseHi = 4'd9;
  localparam logic [CapIdxW-1:0] CapPulseLo = 4'd10;

  localparam logic [ByteW-1:0] ChE     = 8'h65;
  localparam logic [ByteW-1:0] ChR     = 8'h72;
  localparam logic [ByteW-1:0] ChColon = 8'h3A;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;
  localparam logic [ByteW-1:0] ChSeven = 8'h37;

  typedef struct packed {
    logic [ByteW-1:0] systolic;
    logic [ByteW-1:0] diastolic;
    logic [ByteW-1:0] pulse_rate;
  } result_t;

  typedef struct packed {
    logic    emit;
    result_t res;
  } prs_out_t;

  function automatic logic [ByteW-1:0] hdr_char(input logic [HdrPosW-1:0] pos);
    logic [ByteW-1:0] ch;
    unique case (pos)
      3'd0:    ch = ChE;
      3'd1:    ch = ChR;
      3'd2:    ch = ChR;
      3'd3:    ch = ChColon;
      3'd4:    ch = ChZero;
      default: ch = ChE;
    endcase
    return ch;
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] diff;
    diff = (c > ChNine) ? (c - ChSeven) : (c - ChZero);
    return diff[3:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/pmfp_if.sv
`default_nettype none

interface pmfp_in_if;
  logic                          valid;
  logic                          ready;
  logic [pmfp_pkg::ByteW-1:0]    rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pmfp_out_if;
  logic                          valid;
  logic                          ready;
  logic [pmfp_pkg::ByteW-1:0]    systolic;
  logic [pmfp_pkg::ByteW-1:0]    diastolic;
  logic [pmfp_pkg::ByteW-1:0]    pulse_rate;

  modport source (output valid, output systolic, output diastolic, output pulse_rate,
                  input ready);
  modport sink   (input valid, input systolic, input diastolic, input pulse_rate,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/pmfp_in_stage.sv
`default_nettype none

module pmfp_in_stage (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  pmfp_in_if.sink                         in_ch,
  input  wire logic                       adv,
  output      logic                       s1_valid,
  output      logic [pmfp_pkg::ByteW-1:0] s1_byte
);

  logic                       valid_r, valid_nxt;
  logic [pmfp_pkg::ByteW-1:0] byte_r;
  logic                       take;

  assign in_ch.ready = !valid_r || adv;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (take) begin
      byte_r <= in_ch.rx_byte;
    end
  end

  assign s1_valid = valid_r;
  assign s1_byte  = byte_r;

endmodule

`default_nettype wire

>>> rtl/core/pmfp_parser.sv
`default_nettype none

module pmfp_parser (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [pmfp_pkg::ByteW-1:0] cfg_wdata,
  input  wire logic                       step,
  input  wire logic [pmfp_pkg::ByteW-1:0] rx_byte,
  output      pmfp_pkg::prs_out_t         prs
);

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_SKIP = 2'd1,
    PH_CAPT = 2'd2
  } phase_t;

  phase_t                        phase_r, phase_nxt;
  logic [pmfp_pkg::HdrPosW-1:0]  hdr_pos_r, hdr_pos_nxt, hdr_pos_eff;
  logic [pmfp_pkg::ByteW-1:0]    skip_len_r, skip_cnt_r, skip_cnt_nxt, skip_inc;
  logic [pmfp_pkg::CapIdxW-1:0]  cap_idx_r, cap_idx_nxt;
  logic [pmfp_pkg::ByteW-1:0]    sys_r, sys_nxt, dia_r, dia_nxt, pul_r, pul_nxt;
  logic [3:0]                    nib;

  assign nib         = pmfp_pkg::hex_nibble(rx_byte);
  assign skip_inc    = skip_cnt_r + 8'd1;
  assign hdr_pos_eff = (hdr_pos_r > pmfp_pkg::HdrLast) ? '0 : hdr_pos_r;

  always_comb begin
    phase_nxt   = phase_r;
    hdr_pos_nxt = hdr_pos_r;
    skip_cnt_nxt = skip_cnt_r;
    cap_idx_nxt = cap_idx_r;
    sys_nxt     = sys_r;
    dia_nxt     = dia_r;
    pul_nxt     = pul_r;
    unique case (phase_r)
      PH_SKIP: begin
        skip_cnt_nxt = skip_inc;
        if (skip_inc >= skip_len_r) begin
          phase_nxt = PH_CAPT;
        end
      end
      PH_CAPT: begin
        unique case (cap_idx_r)
          pmfp_pkg::CapSysHi:   sys_nxt = {nib, 4'd0};
          pmfp_pkg::CapSysLo:   sys_nxt = {sys_r[7:4], nib};
          pmfp_pkg::CapDiaHi:   dia_nxt = {nib, 4'd0};
          pmfp_pkg::CapDiaLo:   dia_nxt = {dia_r[7:4], nib};
          pmfp_pkg::CapPulseHi: pul_nxt = {nib, 4'd0};
          pmfp_pkg::CapPulseLo: pul_nxt = {pul_r[7:4], nib};
          default: ;
        endcase
        if (cap_idx_r >= pmfp_pkg::CapLast) begin
          cap_idx_nxt = '0;
          hdr_pos_nxt = '0;
          phase_nxt   = PH_HUNT;
        end else begin
          cap_idx_nxt = cap_idx_r + 4'd1;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
        if (rx_byte == pmfp_pkg::hdr_char(hdr_pos_eff)) begin
          if (hdr_pos_eff == pmfp_pkg::HdrLast) begin
            hdr_pos_nxt  = '0;
            skip_cnt_nxt = '0;
            cap_idx_nxt  = '0;
            phase_nxt    = (skip_len_r == '0) ? PH_CAPT : PH_SKIP;
          end else begin
            hdr_pos_nxt = hdr_pos_eff + 3'd1;
          end
        end else begin
          hdr_pos_nxt = '0;
        end
      end
    endcase
  end

  assign prs.emit           = (phase_r == PH_CAPT) && (cap_idx_r >= pmfp_pkg::CapLast);
  assign prs.res.systolic   = sys_nxt;
  assign prs.res.diastolic  = dia_nxt;
  assign prs.res.pulse_rate = pul_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      hdr_pos_r  <= '0;
      skip_cnt_r <= '0;
      cap_idx_r  <= '0;
      sys_r      <= '0;
      dia_r      <= '0;
      pul_r      <= '0;
      skip_len_r <= pmfp_pkg::SkipLenReset;
    end else begin
      if (cfg_we) begin
        skip_len_r <= cfg_wdata;
      end
      if (step) begin
        phase_r    <= phase_nxt;
        hdr_pos_r  <= hdr_pos_nxt;
        skip_cnt_r <= skip_cnt_nxt;
        cap_idx_r  <= cap_idx_nxt;
        sys_r      <= sys_nxt;
        dia_r      <= dia_nxt;
        pul_r      <= pul_nxt;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/pmfp_out_stage.sv
`default_nettype none

module pmfp_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire pmfp_pkg::result_t res,
  output      logic              can_load,
  pmfp_out_if.source             out_ch
);

  logic              valid_r, valid_nxt;
  pmfp_pkg::result_t res_r;

  assign can_load = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.systolic   = res_r.systolic;
  assign out_ch.diastolic  = res_r.diastolic;
  assign out_ch.pulse_rate = res_r.pulse_rate;

endmodule

`default_nettype wire

>>> rtl/core/pressure_monitor_frame_parser_unit.sv
// Blood pressure monitor frame parser.
// in_ch: one received serial character per beat (rx_byte), valid/ready.
// out_ch: one beat per frame with systolic, diastolic and pulse_rate,
//   valid/ready. A frame is the header "err:0", skip_length discarded
//   characters, then an 11-character field block; the result beat follows
//   the eleventh field character.
// cfg_we/cfg_wdata: write skip_length (reset value 30); write only while idle.
// Path: an accepted character is held in the input register, the parser
//   consumes it from there, and a result it completes loads the output register.
// Throughput: one character per cycle unless a frame-completing character stalls,
//   set by the parse step between the input register and the output register.
// Reset (rst_n low, synchronous): parser returns to header search, both
//   channel registers empty, skip_length back to 30.
// Stall: while out_ch holds an untaken result, characters that complete no
//   frame keep flowing; a character that completes a frame waits in the
//   input register until the output register frees up.
`default_nettype none

module pressure_monitor_frame_parser_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [pmfp_pkg::ByteW-1:0] cfg_wdata,
  pmfp_in_if.sink                         in_ch,
  pmfp_out_if.source                      out_ch
);

  logic                       s1_valid;
  logic [pmfp_pkg::ByteW-1:0] s1_byte;
  logic                       adv;
  logic                       can_load;
  pmfp_pkg::prs_out_t         prs;

  assign adv = s1_valid && (!prs.emit || can_load);

  pmfp_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_byte  (s1_byte)
  );

  pmfp_parser u_prs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (adv),
    .rx_byte   (s1_byte),
    .prs       (prs)
  );

  pmfp_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (adv && prs.emit),
    .res      (prs.res),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

`ifndef SYNTHESIS
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

  a_emit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv && prs.emit |=> out_ch.valid)
    else $error("completed frame did not reach output register");

  a_held_byte_stable: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid && !adv |=> s1_valid && $stable(s1_byte))
    else $error("stalled character lost or changed");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.systolic)
      && $stable(out_ch.pulse_rate))
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
